[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each check samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold in every cycle.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that, once true, requires another one in the following cycle.
`define ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/ucg_pkg.sv]
`timescale 1ns / 1ps

package ucg_pkg;

    localparam int LEN_W       = 11;
    localparam int PSUM_W      = 18;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0] UDP_HDR_LEN = 11'd8;
    localparam logic [15:0]      PROTO_UDP   = 16'd17;
    localparam logic [15:0]      SUM_ALL_ONES = 16'hFFFF;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    typedef enum logic
    {
        KIND_START,
        KIND_BYTE
    } kind_t;

    // One classified transaction on its way from the front to the back.
    // For a start, data holds the raw sum of the address and port words;
    // for a byte, the low eight bits hold the payload byte.
    typedef struct packed
    {
        kind_t             kind;
        logic              last;
        logic [PSUM_W-1:0] data;
        logic [LEN_W-1:0]  udp_len;
    } entry_t;

endpackage

[rtl/ucg_front.sv]
`timescale 1ns / 1ps

module ucg_front #(
    parameter int MAX_PAYLOAD = 1472
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [31:0]          dest_address,
    input  logic [15:0]          source_port,
    input  logic [15:0]          dest_port,
    input  logic [15:0]          payload_length,
    input  logic [7:0]           payload_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output ucg_pkg::entry_t      q_entry
);

    logic                       busy_reg;
    logic                       busy_next;
    logic [ucg_pkg::LEN_W-1:0]  remain_reg;
    logic [ucg_pkg::LEN_W-1:0]  remain_next;

    logic                       accept;
    logic [15:0]                len_clamped;
    logic [ucg_pkg::LEN_W-1:0]  len_trim;
    logic [ucg_pkg::PSUM_W-1:0] partial;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        if (payload_length > 16'(MAX_PAYLOAD))
        begin
            len_clamped = 16'(MAX_PAYLOAD);
        end
        else
        begin
            len_clamped = payload_length;
        end
        len_trim = len_clamped[ucg_pkg::LEN_W-1:0];
        partial  = ucg_pkg::PSUM_W'(dest_address[31:16])
                 + ucg_pkg::PSUM_W'(dest_address[15:0])
                 + ucg_pkg::PSUM_W'(source_port)
                 + ucg_pkg::PSUM_W'(dest_port);
    end

    // A byte that arrives with no datagram open is accepted and dropped here.
    always_comb
    begin
        busy_next   = busy_reg;
        remain_next = remain_reg;
        q_push      = 1'b0;
        q_entry     = '0;
        if (cmd == ucg_pkg::CMD_START)
        begin
            q_push          = accept;
            q_entry.kind    = ucg_pkg::KIND_START;
            q_entry.last    = (len_trim == '0);
            q_entry.data    = partial;
            q_entry.udp_len = ucg_pkg::UDP_HDR_LEN + len_trim;
            if (accept)
            begin
                busy_next   = (len_trim != '0);
                remain_next = len_trim;
            end
        end
        else
        begin
            q_push       = accept && busy_reg;
            q_entry.kind = ucg_pkg::KIND_BYTE;
            q_entry.last = (remain_reg == ucg_pkg::LEN_W'(1));
            q_entry.data = ucg_pkg::PSUM_W'(payload_byte);
            if (accept && busy_reg)
            begin
                remain_next = remain_reg - ucg_pkg::LEN_W'(1);
                busy_next   = (remain_reg != ucg_pkg::LEN_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            remain_reg <= remain_next;
        end
    end

endmodule

[rtl/ucg_queue.sv]
`timescale 1ns / 1ps

module ucg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ucg_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ucg_pkg::entry_t head_entry
);

    localparam int PTR_W = $clog2(ucg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ucg_pkg::QUEUE_DEPTH + 1);

    ucg_pkg::entry_t  slots_reg [ucg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(ucg_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == PTR_W'(ucg_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
            end
        end
        if (pop)
        begin
            if (rd_ptr_reg == PTR_W'(ucg_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/ucg_back.sv]
`timescale 1ns / 1ps

module ucg_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [31:0]               cfg_write_data,
    input  logic                      q_valid,
    input  ucg_pkg::entry_t           q_entry,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               checksum,
    output logic [ucg_pkg::LEN_W-1:0] udp_length
);

    logic [15:0]               cfg_sum_reg;
    logic [15:0]               cfg_sum_next;
    logic [15:0]               sum_reg;
    logic [15:0]               sum_next;
    logic [7:0]                held_reg;
    logic [7:0]                held_next;
    logic                      odd_reg;
    logic                      odd_next;
    logic [ucg_pkg::LEN_W-1:0] len_hold_reg;
    logic [ucg_pkg::LEN_W-1:0] len_hold_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [15:0]               checksum_reg;
    logic [15:0]               checksum_next;
    logic [ucg_pkg::LEN_W-1:0] udp_len_reg;
    logic [ucg_pkg::LEN_W-1:0] udp_len_next;

    logic [17:0] cfg_raw;
    logic [16:0] cfg_fold;
    logic [18:0] start_raw;
    logic [16:0] start_fold;
    logic [15:0] start_sum;
    logic [15:0] word;
    logic [16:0] byte_add;
    logic [15:0] byte_sum;
    logic [15:0] final_sum;
    logic [15:0] final_ck;
    logic [7:0]  in_byte;

    // Source address words and the protocol number are constant per
    // configuration, so their folded sum is kept ready.
    always_comb
    begin
        cfg_raw  = 18'(cfg_write_data[31:16]) + 18'(cfg_write_data[15:0])
                 + 18'(ucg_pkg::PROTO_UDP);
        cfg_fold = 17'(cfg_raw[15:0]) + 17'(cfg_raw[17:16]);
        cfg_sum_next = cfg_sum_reg;
        if (cfg_write_en)
        begin
            cfg_sum_next = cfg_fold[15:0] + 16'(cfg_fold[16]);
        end
    end

    // Ones'-complement sums only reach zero when every term is zero, so a
    // double end-around fold of the wide total gives the same word.
    always_comb
    begin
        start_raw  = 19'(q_entry.data) + 19'(cfg_sum_reg)
                   + 19'({q_entry.udp_len, 1'b0});
        start_fold = 17'(start_raw[15:0]) + 17'(start_raw[18:16]);
        start_sum  = start_fold[15:0] + 16'(start_fold[16]);

        in_byte = q_entry.data[7:0];
        if (odd_reg)
        begin
            word = {held_reg, in_byte};
        end
        else
        begin
            word = {in_byte, 8'h00};
        end
        byte_add = 17'(sum_reg) + 17'(word);
        byte_sum = byte_add[15:0] + 16'(byte_add[16]);

        if (q_entry.kind == ucg_pkg::KIND_START)
        begin
            final_sum = start_sum;
        end
        else
        begin
            final_sum = byte_sum;
        end
        final_ck = ~final_sum;
        if (final_ck == '0)
        begin
            final_ck = ucg_pkg::SUM_ALL_ONES;
        end
    end

    assign q_pop = q_valid && (!q_entry.last || !out_valid_reg || out_ready);

    always_comb
    begin
        sum_next       = sum_reg;
        held_next      = held_reg;
        odd_next       = odd_reg;
        len_hold_next  = len_hold_reg;
        out_valid_next = out_valid_reg;
        checksum_next  = checksum_reg;
        udp_len_next   = udp_len_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            if (q_entry.kind == ucg_pkg::KIND_START)
            begin
                sum_next      = start_sum;
                held_next     = '0;
                odd_next      = 1'b0;
                len_hold_next = q_entry.udp_len;
            end
            else if (q_entry.last || odd_reg)
            begin
                sum_next  = byte_sum;
                held_next = '0;
                odd_next  = 1'b0;
            end
            else
            begin
                held_next = in_byte;
                odd_next  = 1'b1;
            end

            if (q_entry.last)
            begin
                out_valid_next = 1'b1;
                checksum_next  = final_ck;
                if (q_entry.kind == ucg_pkg::KIND_START)
                begin
                    udp_len_next = q_entry.udp_len;
                end
                else
                begin
                    udp_len_next = len_hold_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_sum_reg   <= ucg_pkg::PROTO_UDP;
            sum_reg       <= '0;
            held_reg      <= '0;
            odd_reg       <= 1'b0;
            len_hold_reg  <= '0;
            out_valid_reg <= 1'b0;
            checksum_reg  <= '0;
            udp_len_reg   <= '0;
        end
        else
        begin
            cfg_sum_reg   <= cfg_sum_next;
            sum_reg       <= sum_next;
            held_reg      <= held_next;
            odd_reg       <= odd_next;
            len_hold_reg  <= len_hold_next;
            out_valid_reg <= out_valid_next;
            checksum_reg  <= checksum_next;
            udp_len_reg   <= udp_len_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign checksum   = checksum_reg;
    assign udp_length = udp_len_reg;

endmodule

[rtl/udp_checksum_generator.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// UDP checksum generator for IPv4 datagrams.
// The input channel (in_valid/in_ready) carries one transaction per item: a start
// with cmd low brings the destination address, both ports and the payload length,
// and each later transaction with cmd high brings one payload byte. Bytes that
// arrive with no datagram open are accepted and dropped; a new start abandons the
// datagram in progress. The user must write the local source address through
// cfg_write_en and cfg_write_data only while the block is idle (unchecked).
// The output channel (out_valid/out_ready) gives one transaction per datagram:
// the checksum (never zero) and the UDP length, after the last payload byte or
// directly after the start for an empty payload.
// Throughput is one input transaction per cycle while the queue has room.
// A result is written into the two-entry queue when its final input transaction
// is accepted and loads the output register when popped from the queue head.
// When the receiver stalls, the output register holds the result and only a
// transaction that closes another datagram waits at the head of the queue;
// in_ready drops once both queue entries are occupied. Reset clears the queue,
// the datagram state and the output register, and returns the source address
// to zero.
module udp_checksum_generator #(
    parameter int MAX_PAYLOAD = 1472
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] dest_address,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [15:0] payload_length,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] checksum,
    output logic [10:0] udp_length
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    logic            start_accept;
    ucg_pkg::entry_t push_entry;
    ucg_pkg::entry_t head_entry;

    assign start_accept = in_valid && in_ready && (cmd == ucg_pkg::CMD_START);

    ucg_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .dest_address   (dest_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    ucg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    ucg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .q_valid        (q_valid),
        .q_entry        (head_entry),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .checksum       (checksum),
        .udp_length     (udp_length)
    );

    `ASSERT_ALWAYS(a_checksum_nonzero, !out_valid || (checksum != 16'h0000), "zero checksum sent")
    `ASSERT_NEXT(a_start_queued, start_accept, q_valid, "start transaction not queued")
    `ASSERT_ALWAYS(a_pop_has_data, !q_pop || q_valid, "pop from empty queue")

endmodule

[sim/udp_checksum_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the checksum generator. It predicts each result from
// the accepted input transactions and compares it with what the block returns.
module udp_checksum_checker
    import ucg_pkg::*;
#(
    parameter int MAX_PAYLOAD = 1472
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] dest_address,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [15:0] payload_length,
    input  logic [7:0]  payload_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] checksum,
    input  logic [10:0] udp_length,
    output int          mismatch_count,
    output int          expected_count,
    output int          results_checked
);

    localparam int REPORT_LIMIT = 50;

    typedef struct packed
    {
        logic [15:0]      csum;
        logic [LEN_W-1:0] len;
    } udp_result_t;

    udp_result_t      expected_results[$];
    udp_result_t      oldest;
    logic [31:0]      local_address;
    logic [15:0]      acc_sum;
    logic [15:0]      clamped_len;
    logic [LEN_W-1:0] bytes_left;
    logic [LEN_W-1:0] length_field;
    logic [7:0]       high_byte;
    logic             have_high;
    logic             dgram_open;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + 16'(s[16]);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // An unpaired final byte is padded with a zero low byte before the sum is
    // complemented; a zero checksum goes out as all ones.
    task automatic close_datagram();
        logic [15:0] final_sum;
        udp_result_t res;
        final_sum = have_high ? ones_add(acc_sum, {high_byte, 8'h00}) : acc_sum;
        res.csum = ~final_sum;
        if (res.csum == 16'h0000)
            res.csum = SUM_ALL_ONES;
        res.len = length_field;
        expected_results.push_back(res);
        dgram_open = 1'b0;
        have_high = 1'b0;
        high_byte = 8'h00;
        bytes_left = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address = 32'h0;
            acc_sum = 16'h0;
            bytes_left = '0;
            length_field = '0;
            high_byte = 8'h00;
            have_high = 1'b0;
            dgram_open = 1'b0;
            expected_results.delete();
            mismatch_count = 0;
            results_checked = 0;
            expected_count <= 0;
        end
        else
        begin
            if (cfg_write_en)
                local_address = cfg_write_data;

            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with none expected: checksum %04h length %0d",
                                              checksum, udp_length));
                else
                begin
                    oldest = expected_results.pop_front();
                    results_checked++;
                    if (checksum !== oldest.csum)
                        report_mismatch($sformatf("checksum %04h, expected %04h",
                                                  checksum, oldest.csum));
                    if (udp_length !== oldest.len)
                        report_mismatch($sformatf("udp_length %0d, expected %0d",
                                                  udp_length, oldest.len));
                end
            end

            if (in_valid && in_ready)
            begin
                if (cmd == CMD_START)
                begin
                    // A start always begins a fresh sum, abandoning any open datagram.
                    clamped_len = (payload_length > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD)
                                                                 : payload_length;
                    length_field = UDP_HDR_LEN + clamped_len[LEN_W-1:0];
                    acc_sum = ones_add(16'h0, local_address[31:16]);
                    acc_sum = ones_add(acc_sum, local_address[15:0]);
                    acc_sum = ones_add(acc_sum, dest_address[31:16]);
                    acc_sum = ones_add(acc_sum, dest_address[15:0]);
                    acc_sum = ones_add(acc_sum, PROTO_UDP);
                    acc_sum = ones_add(acc_sum, 16'(length_field));
                    acc_sum = ones_add(acc_sum, source_port);
                    acc_sum = ones_add(acc_sum, dest_port);
                    acc_sum = ones_add(acc_sum, 16'(length_field));
                    bytes_left = clamped_len[LEN_W-1:0];
                    high_byte = 8'h00;
                    have_high = 1'b0;
                    dgram_open = 1'b1;
                    if (bytes_left == '0)
                        close_datagram();
                end
                else if (dgram_open)
                begin
                    if (!have_high)
                    begin
                        high_byte = payload_byte;
                        have_high = 1'b1;
                    end
                    else
                    begin
                        acc_sum = ones_add(acc_sum, {high_byte, payload_byte});
                        high_byte = 8'h00;
                        have_high = 1'b0;
                    end
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == '0)
                        close_datagram();
                end
            end

            expected_count <= expected_results.size();
        end
    end

endmodule

[sim/tb_udp_checksum_generator.sv]
`timescale 1ns / 1ps

module tb_udp_checksum_generator;
    import ucg_pkg::*;

    localparam int MAX_PAYLOAD   = 1472;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [31:0] cfg_write_data = 32'h0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = CMD_START;
    logic [31:0] dest_address = 32'h0;
    logic [15:0] source_port = 16'h0;
    logic [15:0] dest_port = 16'h0;
    logic [15:0] payload_length = 16'h0;
    logic [7:0]  payload_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] checksum;
    logic [10:0] udp_length;

    int mismatches;
    int pending;
    int compared;
    int items_accepted = 0;
    int starts_sent = 0;
    bit sender_burst = 1'b0;

    udp_checksum_generator #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .dest_address(dest_address),
        .source_port(source_port),
        .dest_port(dest_port),
        .payload_length(payload_length),
        .payload_byte(payload_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .checksum(checksum),
        .udp_length(udp_length)
    );

    udp_checksum_checker #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) csum_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .dest_address(dest_address),
        .source_port(source_port),
        .dest_port(dest_port),
        .payload_length(payload_length),
        .payload_byte(payload_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .checksum(checksum),
        .udp_length(udp_length),
        .mismatch_count(mismatches),
        .expected_count(pending),
        .results_checked(compared)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mostly short idle stretches with the occasional long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    task automatic drive_item(input logic c, input logic [31:0] dst, input logic [15:0] sport,
                              input logic [15:0] dport, input logic [15:0] len,
                              input logic [7:0] b);
        int gap;
        gap = (!sender_burst && $urandom_range(0, 1) == 1) ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        dest_address <= dst;
        source_port <= sport;
        dest_port <= dport;
        payload_length <= len;
        payload_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_accepted++;
    endtask

    task automatic send_start(input logic [31:0] dst, input logic [15:0] sport,
                              input logic [15:0] dport, input logic [15:0] len);
        drive_item(CMD_START, dst, sport, dport, len, 8'($urandom));
        starts_sent++;
    endtask

    // The header fields are don't-care on a byte, so they carry noise.
    task automatic send_byte(input logic [7:0] b);
        drive_item(CMD_BYTE, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), b);
    endtask

    task automatic run_datagram(input logic [15:0] len, input int nbytes);
        send_start($urandom, 16'($urandom), 16'($urandom), len);
        repeat (nbytes) send_byte(8'($urandom));
    endtask

    // Holds the sender off until every predicted result has been taken, then lets
    // the pipeline settle so the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_source(input logic [31:0] addr);
        cfg_write_en <= 1'b1;
        cfg_write_data <= addr;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Receiver side: random stalls, with stretches where it never stalls.
    initial
    begin : receiver
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left = 0;
        forever
        begin
            @(posedge clk);
            if (calm_left > 0)
            begin
                calm_left--;
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 3)
                    calm_left = $urandom_range(50, 300);
                else if ($urandom_range(0, 99) < 30)
                    stall_left = idle_length();
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int quota_done;
        int nbytes;
        logic [15:0] len;
        logic [15:0] clamped;
        logic [31:0] addr;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_source(32'h0000_0000);
        send_byte(8'hFF);
        // With a zero source address this header sums to all ones, so the
        // complemented checksum is zero and must go out as 0xFFFF.
        send_start(32'h0000_0000, 16'h0000, 16'hFFDE, 16'd0);
        send_start(32'h0000_0000, 16'h0000, 16'h0000, 16'd0);
        send_start(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_start(32'hC0A8_0102, 16'd1024, 16'd53, 16'd1);
        send_byte(8'hFF);
        send_start(32'h7F00_0001, 16'hFFFF, 16'h0000, 16'd2);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_start(32'h0A00_0001, 16'h0000, 16'hFFFF, 16'd3);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        // Two oversized datagrams, each cut short by the next start.
        send_start(32'hFFFF_FFFF, 16'h8000, 16'h0001, 16'hFFFF);
        send_byte(8'hAB);
        send_byte(8'hCD);
        send_start(32'h8000_0000, 16'h1234, 16'h4321, 16'd1473);
        send_byte(8'h12);
        send_start(32'h5555_AAAA, 16'hAAAA, 16'h5555, 16'd4);
        repeat (4) send_byte(8'($urandom));
        send_byte(8'h00);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: addr = 32'hFFFF_FFFF;
                1: addr = 32'h0000_FFFF;
                3: addr = 32'hFFFF_0000;
                default: addr = $urandom;
            endcase
            write_source(addr);
            quota_done = 0;

            if (p == 2)
            begin
                // One full datagram whose length is clamped to the maximum payload.
                sender_burst = 1'b0;
                run_datagram(16'($urandom_range(MAX_PAYLOAD + 1, 65535)), MAX_PAYLOAD);
            end

            while (quota_done < PHASE_ITEMS)
            begin
                sender_burst = ($urandom_range(0, 7) == 0);
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        len = 16'($urandom_range(0, 2));
                    else if (r < 85)
                        len = 16'($urandom_range(3, 40));
                    else
                        len = 16'($urandom_range(41, 200));
                    run_datagram(len, len);
                    quota_done += len + 1;
                end
                else if (r < 88)
                begin
                    // Usually left open and abandoned by whatever start follows.
                    len = 16'($urandom);
                    clamped = (len > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD) : len;
                    nbytes = $urandom_range(0, 6);
                    if (nbytes > clamped)
                        nbytes = clamped;
                    run_datagram(len, nbytes);
                    quota_done += nbytes + 1;
                end
                else
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end

            // An empty datagram closes anything left open before the next write.
            run_datagram(16'd0, 0);
            drain();
        end

        $display("Sent %0d input transactions, %0d of them datagram starts; %0d results compared.",
                 items_accepted, starts_sent, compared);
        $display("Covered empty, odd, abandoned and clamped payloads under %0d source addresses.",
                 PHASES + 1);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Run stopped by the time limit with %0d results outstanding.", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule
